// File: rtl/core/rmt_pkg.sv
// ----------------------------------------------------------------------------
// rmt_pkg: shared types and constants of the ring mesh tessellator
// Widths, the CORDIC arctangent table and the pipeline payload structs.
// ----------------------------------------------------------------------------
package rmt_pkg;

  localparam int MaxSegments = 1024;
  localparam int PhaseBits   = 16;
  localparam int IdxW        = 10;
  localparam int CntW        = 11;
  localparam int NumW        = IdxW + PhaseBits;   // dividend width
  localparam int CordicSteps = 30;
  localparam int StepsPerStg = 3;
  localparam int CordicStg   = CordicSteps / StepsPerStg;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  localparam logic [2:0] RegCenterX = 3'd0;
  localparam logic [2:0] RegCenterY = 3'd1;
  localparam logic [2:0] RegOuterR  = 3'd2;
  localparam logic [2:0] RegInnerR  = 3'd3;
  localparam logic [2:0] RegSegCnt  = 3'd4;
  localparam logic [2:0] RegColor   = 3'd5;

  function automatic logic signed [33:0] atan_turn(input int k);
    logic signed [33:0] t;
    unique case (k)
      0: t = 34'sd536870912;  1: t = 34'sd316933406;  2: t = 34'sd167458907;
      3: t = 34'sd85004756;   4: t = 34'sd42667331;   5: t = 34'sd21354465;
      6: t = 34'sd10679838;   7: t = 34'sd5340245;    8: t = 34'sd2670163;
      9: t = 34'sd1335087;   10: t = 34'sd667544;    11: t = 34'sd333772;
      12: t = 34'sd166886;   13: t = 34'sd83443;     14: t = 34'sd41722;
      15: t = 34'sd20861;    16: t = 34'sd10430;     17: t = 34'sd5215;
      18: t = 34'sd2608;     19: t = 34'sd1304;      20: t = 34'sd652;
      21: t = 34'sd326;      22: t = 34'sd163;       23: t = 34'sd81;
      24: t = 34'sd41;       25: t = 34'sd20;        26: t = 34'sd10;
      27: t = 34'sd5;        28: t = 34'sd3;         29: t = 34'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Side data that rides along with the arithmetic.
  typedef struct packed {
    logic            invalid;
    logic [CntW-1:0] a0;
    logic [CntW-1:0] a1;
    logic [CntW-1:0] a2;
    logic [CntW-1:0] b1;
  } side_t;

  typedef struct packed {
    logic signed [31:0] outer_x;
    logic signed [31:0] outer_y;
    logic signed [31:0] inner_x;
    logic signed [31:0] inner_y;
    logic [23:0]        color_out;
    logic [CntW-1:0]    tri_a0;
    logic [CntW-1:0]    tri_a1;
    logic [CntW-1:0]    tri_a2;
    logic [CntW-1:0]    tri_b0;
    logic [CntW-1:0]    tri_b1;
    logic [CntW-1:0]    tri_b2;
    logic               index_invalid;
  } result_t;

endpackage

// File: rtl/core/rmt_if.sv
// ----------------------------------------------------------------------------
// rmt_if: valid/ready channel interfaces
// Segment request, result and configuration write channels.
// ----------------------------------------------------------------------------
interface rmt_seg_if;
  logic       valid;
  logic       ready;
  logic [9:0] segment_index;
  modport source  (output valid, output segment_index, input ready);
  modport sink    (input valid, input segment_index, output ready);
  modport monitor (input valid, input segment_index, input ready);
endinterface

interface rmt_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] outer_x;
  logic signed [31:0] outer_y;
  logic signed [31:0] inner_x;
  logic signed [31:0] inner_y;
  logic [23:0]        color_out;
  logic [10:0]        tri_a0;
  logic [10:0]        tri_a1;
  logic [10:0]        tri_a2;
  logic [10:0]        tri_b0;
  logic [10:0]        tri_b1;
  logic [10:0]        tri_b2;
  logic               index_invalid;
  modport source  (output valid, outer_x, outer_y, inner_x, inner_y, color_out,
                   tri_a0, tri_a1, tri_a2, tri_b0, tri_b1, tri_b2, index_invalid,
                   input ready);
  modport sink    (input valid, outer_x, outer_y, inner_x, inner_y, color_out,
                   tri_a0, tri_a1, tri_a2, tri_b0, tri_b1, tri_b2, index_invalid,
                   output ready);
  modport monitor (input valid, outer_x, outer_y, inner_x, inner_y, color_out,
                   tri_a0, tri_a1, tri_a2, tri_b0, tri_b1, tri_b2, index_invalid,
                   ready);
endinterface

interface rmt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source  (output valid, index, data, input ready);
  modport sink    (input valid, index, data, output ready);
  modport monitor (input valid, index, data, ready);
endinterface

// File: rtl/core/rmt_div.sv
// ----------------------------------------------------------------------------
// rmt_div: pipelined restoring divider
// Computes floor((i << PhaseBits) / n), one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmt_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [rmt_pkg::IdxW-1:0] in_idx,
  input  logic [rmt_pkg::CntW-1:0] in_n,
  input  rmt_pkg::side_t           in_side,
  output logic                     out_valid,
  output logic [rmt_pkg::PhaseBits-1:0] out_phase,
  output rmt_pkg::side_t           out_side
);
  import rmt_pkg::*;

  // Quotient bits above PhaseBits are zero since i < n; only the low
  // PhaseBits quotient bits are produced, starting from remainder i < n.
  // An index at or above n gives a quotient that is never used.
  localparam int S = PhaseBits;

  logic [S:0]          vld;
  logic [CntW:0]       rem [S+1];
  logic [S-1:0]        quo [S+1];
  logic [CntW-1:0]     den [S+1];
  side_t               sd  [S+1];

  assign vld[0] = in_valid;
  assign rem[0] = {2'b00, in_idx};
  assign quo[0] = '0;
  assign den[0] = in_n;
  assign sd[0]  = in_side;

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [CntW:0] sh;
    logic [CntW:0] df;
    assign sh = {rem[s][CntW-1:0], 1'b0};
    assign df = sh - {1'b0, den[s]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s+1] <= (sh >= {1'b0, den[s]}) ? df : sh;
        quo[s+1] <= {quo[s][S-2:0], sh >= {1'b0, den[s]}};
        den[s+1] <= den[s];
        sd[s+1]  <= sd[s];
      end
    end
  end

  assign out_valid = vld[S];
  assign out_phase = quo[S];
  assign out_side  = sd[S];
endmodule

// File: rtl/core/rmt_cordic.sv
// ----------------------------------------------------------------------------
// rmt_cordic: pipelined rotation-mode CORDIC
// Three micro-rotations per stage, then a quadrant fold stage.
// ----------------------------------------------------------------------------
module rmt_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [rmt_pkg::PhaseBits-1:0] in_phase,
  input  rmt_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic signed [33:0]            out_cos,
  output logic signed [33:0]            out_sin,
  output rmt_pkg::side_t                out_side
);
  import rmt_pkg::*;

  localparam int S = CordicStg;

  logic [31:0] turn;
  assign turn = {in_phase, (32-PhaseBits)'(0)};

  logic [S:0]         vld;
  logic signed [33:0] xr [S+1];
  logic signed [33:0] yr [S+1];
  logic signed [33:0] zr [S+1];
  logic [1:0]         qd [S+1];
  side_t              sd [S+1];

  assign vld[0] = in_valid;
  assign xr[0]  = CordicGain;
  assign yr[0]  = '0;
  assign zr[0]  = {4'b0, turn[29:0]};
  assign qd[0]  = turn[31:30];
  assign sd[0]  = in_side;

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic signed [33:0] x_n, y_n, z_n;
    always_comb begin
      logic signed [33:0] x, y, z, dx, dy;
      x = xr[s]; y = yr[s]; z = zr[s];
      for (int j = 0; j < StepsPerStg; j++) begin
        dx = y >>> (s*StepsPerStg + j);
        dy = x >>> (s*StepsPerStg + j);
        if (!z[33]) begin
          x = x - dx; y = y + dy; z = z - atan_turn(s*StepsPerStg + j);
        end else begin
          x = x + dx; y = y - dy; z = z + atan_turn(s*StepsPerStg + j);
        end
      end
      x_n = x; y_n = y; z_n = z;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        xr[s+1] <= x_n; yr[s+1] <= y_n; zr[s+1] <= z_n;
        qd[s+1] <= qd[s]; sd[s+1] <= sd[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[S];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_side <= sd[S];
      unique case (qd[S])
        2'd0: begin out_cos <= xr[S];  out_sin <= yr[S];  end
        2'd1: begin out_cos <= -yr[S]; out_sin <= xr[S];  end
        2'd2: begin out_cos <= -xr[S]; out_sin <= -yr[S]; end
        default: begin out_cos <= yr[S]; out_sin <= -xr[S]; end
      endcase
    end
  end
endmodule

// File: rtl/core/rmt_place.sv
// ----------------------------------------------------------------------------
// rmt_place: vertex placement
// Scales the unit vector by both radii, rounds, adds the center, saturates.
// ----------------------------------------------------------------------------
module rmt_place (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [33:0] in_cos,
  input  logic signed [33:0] in_sin,
  input  rmt_pkg::side_t     in_side,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic [30:0]        outer_radius,
  input  logic [30:0]        inner_radius,
  input  logic [23:0]        vertex_color,
  output logic               out_valid,
  output rmt_pkg::result_t   out_res
);
  import rmt_pkg::*;

  // An invalid index clears every field but the flag.
  localparam result_t InvalidRes = '{index_invalid: 1'b1, default: '0};

  // Stage 1: four products (32x34 signed).
  logic               v1;
  logic signed [65:0] pox, poy, pix, piy;
  side_t              s1;
  // Stage 2: rounded offsets.
  logic               v2;
  logic signed [35:0] oox, ooy, oix, oiy;
  side_t              s2;

  function automatic logic signed [35:0] rnd(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = (p + 66'sd536870912) >>> 30;
    return t[35:0];
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [31:0] c,
                                             input logic signed [35:0] o);
    logic signed [36:0] v;
    v = 37'(c) + 37'(o);
    if (v > 37'sd2147483647)       return 32'sh7fffffff;
    else if (v < -37'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pox <= $signed({1'b0, outer_radius}) * in_cos;
      poy <= $signed({1'b0, outer_radius}) * in_sin;
      pix <= $signed({1'b0, inner_radius}) * in_cos;
      piy <= $signed({1'b0, inner_radius}) * in_sin;
      s1  <= in_side;
      oox <= rnd(pox); ooy <= rnd(poy); oix <= rnd(pix); oiy <= rnd(piy);
      s2  <= s1;
      if (s2.invalid) begin
        out_res <= InvalidRes;
      end else begin
        out_res.outer_x <= sat(center_x, oox);
        out_res.outer_y <= sat(center_y, ooy);
        out_res.inner_x <= sat(center_x, oix);
        out_res.inner_y <= sat(center_y, oiy);
        out_res.color_out <= vertex_color;
        out_res.tri_a0 <= s2.a0;
        out_res.tri_a1 <= s2.a1;
        out_res.tri_a2 <= s2.a2;
        out_res.tri_b0 <= s2.a1;
        out_res.tri_b1 <= s2.b1;
        out_res.tri_b2 <= s2.a2;
        out_res.index_invalid <= 1'b0;
      end
    end
  end

  property p_inv_zero;
    @(posedge clk) disable iff (rst)
      (out_valid && out_res.index_invalid) |-> (out_res.color_out == '0);
  endproperty
  a_inv_zero: assert property (p_inv_zero) else $error("invalid result not cleared");

  property p_tri_dup;
    @(posedge clk) disable iff (rst)
      out_valid |-> (out_res.tri_a1 == out_res.tri_b0 && out_res.tri_a2 == out_res.tri_b2);
  endproperty
  a_tri_dup: assert property (p_tri_dup) else $error("shared triangle indices differ");

  property p_hold;
    @(posedge clk) disable iff (rst) !adv |=> $stable(out_valid);
  endproperty
  a_hold: assert property (p_hold) else $error("pipeline moved during stall");
endmodule

// File: rtl/core/ring_mesh_tessellator.sv
// ----------------------------------------------------------------------------
// ring_mesh_tessellator: annulus mesh tessellation, one segment per request
// Gives the outer and inner vertex and the two triangles of segment i.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  seg     | in        | segment_index
//  res     | out       | vertices, color, triangle indices, invalid flag
//  cfg     | in        | register index, 32-bit write data
//
// One request per cycle is taken unless the pipeline stalls. It has 16 divider
// stages, 10 CORDIC stages plus one quadrant stage and 3 placement stages.
// The whole pipeline advances together; it stalls only when the output
// register holds a result that the sink has not taken, so nothing is lost.
// Reset is synchronous: valid bits and configuration clear, segment count is 1.
module ring_mesh_tessellator (
  input logic clk,
  input logic rst,
  rmt_seg_if.sink   seg,
  rmt_res_if.source res,
  rmt_cfg_if.sink   cfg
);
  import rmt_pkg::*;

  logic signed [31:0] center_x, center_y;
  logic [30:0]        outer_radius, inner_radius;
  logic [CntW-1:0]    segment_count;
  logic [23:0]        vertex_color;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0; center_y <= '0; outer_radius <= '0; inner_radius <= '0;
      segment_count <= CntW'(1); vertex_color <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegCenterX: center_x      <= cfg.data;
        RegCenterY: center_y      <= cfg.data;
        RegOuterR:  outer_radius  <= cfg.data[30:0];
        RegInnerR:  inner_radius  <= cfg.data[30:0];
        RegSegCnt:  segment_count <= cfg.data[CntW-1:0];
        RegColor:   vertex_color  <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  // Effective segment count, clamped to the mesh maximum.
  logic [CntW-1:0] seg_n;
  assign seg_n = (segment_count > CntW'(MaxSegments)) ? CntW'(MaxSegments)
                                                      : segment_count;

  // The pipeline advances whenever the output slot is empty or being drained.
  logic adv;
  logic out_valid;
  result_t out_res;
  assign adv = !out_valid || res.ready;
  assign seg.ready = adv;

  // Triangle indices are worked out at the entry.
  side_t side_in;
  logic [CntW-1:0] i_w, nxt;
  always_comb begin
    i_w = CntW'(seg.segment_index);
    nxt = (i_w + CntW'(1) == seg_n) ? '0 : i_w + CntW'(1);
    side_in.invalid = (i_w >= seg_n);
    side_in.a0 = i_w;
    side_in.a1 = nxt;
    side_in.a2 = i_w + seg_n;
    side_in.b1 = nxt + seg_n;
  end

  logic                 d_valid;
  logic [PhaseBits-1:0] d_phase;
  side_t                d_side;
  rmt_div u_div (
    .clk, .rst, .adv,
    .in_valid (seg.valid && seg.ready),
    .in_idx   (seg.segment_index),
    .in_n     (seg_n),
    .in_side  (side_in),
    .out_valid(d_valid),
    .out_phase(d_phase),
    .out_side (d_side)
  );

  logic               c_valid;
  logic signed [33:0] c_cos, c_sin;
  side_t              c_side;
  rmt_cordic u_cordic (
    .clk, .rst, .adv,
    .in_valid (d_valid),
    .in_phase (d_phase),
    .in_side  (d_side),
    .out_valid(c_valid),
    .out_cos  (c_cos),
    .out_sin  (c_sin),
    .out_side (c_side)
  );

  rmt_place u_place (
    .clk, .rst, .adv,
    .in_valid    (c_valid),
    .in_cos      (c_cos),
    .in_sin      (c_sin),
    .in_side     (c_side),
    .center_x, .center_y, .outer_radius, .inner_radius, .vertex_color,
    .out_valid,
    .out_res
  );

  assign res.valid         = out_valid;
  assign res.outer_x       = out_res.outer_x;
  assign res.outer_y       = out_res.outer_y;
  assign res.inner_x       = out_res.inner_x;
  assign res.inner_y       = out_res.inner_y;
  assign res.color_out     = out_res.color_out;
  assign res.tri_a0        = out_res.tri_a0;
  assign res.tri_a1        = out_res.tri_a1;
  assign res.tri_a2        = out_res.tri_a2;
  assign res.tri_b0        = out_res.tri_b0;
  assign res.tri_b1        = out_res.tri_b1;
  assign res.tri_b2        = out_res.tri_b2;
  assign res.index_invalid = out_res.index_invalid;

  property p_seg_n_range;
    @(posedge clk) disable iff (rst) seg_n <= CntW'(MaxSegments);
  endproperty
  a_seg_n_range: assert property (p_seg_n_range) else $error("segment count not clamped");

  property p_stall_hold;
    @(posedge clk) disable iff (rst)
      (res.valid && !res.ready) |=> (res.valid && $stable(res.tri_a0));
  endproperty
  a_stall_hold: assert property (p_stall_hold) else $error("result dropped on stall");

  property p_no_accept_stall;
    @(posedge clk) disable iff (rst) (res.valid && !res.ready) |-> !seg.ready;
  endproperty
  a_no_accept_stall: assert property (p_no_accept_stall) else $error("accept while stalled");
endmodule
